// ----- design/kdns_pkg.sv -----
// Shared types and constants for the kd-tree nearest search block.
package kdns_pkg;
  localparam int MaxNodes  = 1024;
  localparam int Dims      = 3;
  localparam int CoordBits = 16;
  localparam int AddrBits  = $clog2(MaxNodes);
  localparam int CntBits   = AddrBits + 1;
  localparam int DistBits  = 35;
  localparam int OutBits   = 34;
  localparam int QDepth    = 2;
  localparam logic [DistBits-1:0] BestNone = {DistBits{1'b1}};
  localparam logic [DistBits-1:0] DistSat  = BestNone - 1'b1;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic             cmd;
    logic [AddrBits-1:0] addr;
    logic [1:0]       dim;
    coord_t [3:0]     pt;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DREAD, S_DTEST, S_UREAD, S_UTEST,
    S_DIST0, S_DIST1, S_DIST2, S_DIST3, S_DECIDE, S_DONE
  } state_t;
endpackage

// ----- design/kdns_front.sv -----
// Front part: accepts requests, zeroes unused coordinates and queues them.
module kdns_front
  import kdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  output logic        s_ready,
  input  item_t       s_item,
  output logic        q_valid,
  input  logic        q_take,
  output item_t       q_item
);
  item_t slots [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth):0]   fill;
  item_t clean;
  logic push, pop;

  always_comb begin
    clean = s_item;
    for (int k = 0; k < 4; k++) begin
      if (k >= Dims) clean.pt[k] = '0;
    end
  end

  assign s_ready = (fill != ($clog2(QDepth)+1)'(QDepth));
  assign q_valid = (fill != '0);
  assign q_item  = slots[rp];
  assign push = s_valid && s_ready;
  assign pop  = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= clean;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, pop};
    end
  end
endmodule

// ----- design/kdns_back.sv -----
// Back part: node memory and the stackless search sequencer.
module kdns_back
  import kdns_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CntBits-1:0]   node_count,
  input  logic                 q_valid,
  output logic                 q_take,
  input  item_t                q_item,
  output logic                 r_valid,
  input  logic                 r_ready,
  output logic [OutBits+AddrBits:0] r_data
);
  logic [1:0]    dim_mem [MaxNodes];
  coord_t [3:0]  pt_mem  [MaxNodes];
  logic [1:0]    rd_dim;
  coord_t [3:0]  rd_pt;
  logic [AddrBits-1:0] raddr;

  state_t state, state_next;
  item_t  cur;
  logic [CntBits:0]    idx;      // walk index, may exceed node range
  logic [CntBits:0]    prev;
  logic [DistBits-1:0] best, acc;
  logic [AddrBits-1:0] best_node;
  logic                have;
  logic [CntBits-1:0]  cnt;
  logic signed [CoordBits:0] gap;
  logic [DistBits-1:0] gsq, dsq;
  logic [1:0]          kk;
  logic signed [CoordBits:0] dk;
  logic [CntBits:0]    parent;

  assign parent = (idx - 1'b1) >> 1;

  // The parent is read on the climb and held through the test cycle, so the
  // distance cycles that follow a far-side hit see the parent's point.
  always_comb begin
    unique case (state)
      S_UREAD, S_UTEST: raddr = parent[AddrBits-1:0];
      default: raddr = idx[AddrBits-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && {1'b0, cur.addr} < CntBits'(MaxNodes)) begin
      dim_mem[cur.addr] <= cur.dim;
      pt_mem[cur.addr]  <= cur.pt;
    end
    rd_dim <= dim_mem[raddr];
    rd_pt  <= pt_mem[raddr];
  end

  function automatic logic [DistBits-1:0] sqs(input logic signed [CoordBits:0] d);
    logic [CoordBits:0] a;
    logic [2*CoordBits+1:0] s;
    a = d[CoordBits] ? -d : d;
    s = a * a;
    return ({1'b0, s} > DistSat) ? DistSat : DistBits'(s);
  endfunction

  assign gap = {rd_pt[rd_dim][CoordBits-1], rd_pt[rd_dim]} -
               {cur.pt[rd_dim][CoordBits-1], cur.pt[rd_dim]};
  assign gsq = sqs(gap);
  always_comb begin
    unique case (state)
      S_DIST1: kk = 2'd1;
      S_DIST2: kk = 2'd2;
      S_DIST3: kk = 2'd3;
      default: kk = 2'd0;
    endcase
  end
  assign dk  = {rd_pt[kk][CoordBits-1], rd_pt[kk]} -
               {cur.pt[kk][CoordBits-1], cur.pt[kk]};
  assign dsq = sqs(dk);

  logic from_lo, prev_even, climb_hit, done_fire;
  assign from_lo   = !gap[CoordBits];
  assign prev_even = !prev[0];
  assign climb_hit = (from_lo != prev_even) && (gsq < best);
  assign done_fire = (state == S_DONE) && (!r_valid || r_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid) state_next = (q_item.cmd == CmdLoad) ? S_LOAD : S_DREAD;
      S_LOAD:  state_next = S_IDLE;
      S_DREAD: state_next = (idx < {1'b0, cnt}) ? S_DTEST :
                            (idx == '0) ? S_DONE : S_UREAD;
      S_DTEST: state_next = S_DREAD;
      S_UREAD: state_next = S_UTEST;
      S_UTEST: state_next = climb_hit ? S_DIST0 : ((parent == '0) ? S_DONE : S_UREAD);
      S_DIST0: state_next = S_DIST1;
      S_DIST1: state_next = S_DIST2;
      S_DIST2: state_next = S_DIST3;
      S_DIST3: state_next = S_DECIDE;
      S_DECIDE: state_next = S_DREAD;
      S_DONE:  if (!r_valid || r_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign q_take = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r_valid <= 1'b0;
    end else begin
      state <= state_next;
      r_valid <= done_fire || (r_valid && !r_ready);
    end
    unique case (state)
      S_IDLE: if (q_valid) begin
        cur  <= q_item;
        idx  <= '0;
        best <= BestNone;
        best_node <= '0;
        have <= 1'b0;
        cnt  <= (node_count > CntBits'(MaxNodes)) ? CntBits'(MaxNodes) : node_count;
      end
      S_DTEST: idx <= (cur.pt[rd_dim] <= rd_pt[rd_dim]) ? {idx[CntBits-1:0], 1'b1}
                                                        : ({idx[CntBits-1:0], 1'b0} + 2'd2);
      S_DREAD: if (!(idx < {1'b0, cnt}) && idx != '0) prev <= idx;
      S_UTEST: begin
        idx  <= (prev - 1'b1) >> 1;
        prev <= climb_hit ? {{CntBits{1'b0}}, from_lo} : ((prev - 1'b1) >> 1);
      end
      S_DIST0: acc <= dsq;
      S_DIST1, S_DIST2, S_DIST3: begin
        if (acc + dsq > DistSat) acc <= DistSat;
        else acc <= acc + dsq;
      end
      S_DECIDE: begin
        if (acc < best) begin
          best <= acc;
          best_node <= idx[AddrBits-1:0];
          have <= 1'b1;
        end
        idx <= {idx[CntBits-1:0], 1'b0} + (prev[0] ? 2'd2 : 2'd1);
      end
      S_DONE: if (!r_valid || r_ready) begin
        r_data[0] <= have;
        r_data[AddrBits:1] <= have ? best_node : '0;
        r_data[OutBits+AddrBits:AddrBits+1] <= !have ? '0 :
          (best > DistBits'({OutBits{1'b1}})) ? {OutBits{1'b1}} : best[OutBits-1:0];
      end
      default: ;
    endcase
    if (state == S_UREAD) prev <= idx;
  end
endmodule

// ----- design/kd_tree_nearest_search.sv -----
// Top level of the kd-tree nearest search block.
//
//  channel  | direction | contents
//  s_axis   | in        | cmd (tuser), node_addr, node_dim, coord_0..coord_3 (tdata)
//  m_axis   | out       | found (tuser), nearest_node, dist_squared (tdata)
//  cfg      | in        | node_count write
//
// A load request is taken from the queue and then its node is written. A query
// is taken, then walks down the tree with a read and a test state per node
// until the walk leaves the tree, climbs with a read and a test state per step,
// runs the distance states and a decide state for each far-side visit, and
// hands over the result; each step has one registered node memory read.
// Reset (rst, synchronous) empties the request queue and the result register.
// The two-entry queue accepts requests while a search stalls on m_axis, until it is full.
module kd_tree_nearest_search
  import kdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // node_addr, node_dim, coord_0..coord_3, zero pad
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // nearest_node, dist_squared, zero pad
  output logic        m_axis_tuser   // found
);
  logic [CntBits-1:0] node_count;
  item_t in_item, q_item;
  logic q_valid, q_take;
  logic [OutBits+AddrBits:0] r_data;

  always_ff @(posedge clk) begin
    if (rst) node_count <= '0;
    else if (cfg_we) node_count <= cfg_wdata;
  end

  assign in_item.cmd   = s_axis_tuser;
  assign in_item.addr  = s_axis_tdata[9:0];
  assign in_item.dim   = s_axis_tdata[11:10];
  assign in_item.pt[0] = s_axis_tdata[27:12];
  assign in_item.pt[1] = s_axis_tdata[43:28];
  assign in_item.pt[2] = s_axis_tdata[59:44];
  assign in_item.pt[3] = s_axis_tdata[75:60];

  kdns_front u_front (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_item(in_item),
    .q_valid, .q_take, .q_item
  );

  kdns_back u_back (
    .clk, .rst, .node_count,
    .q_valid, .q_take, .q_item,
    .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data
  );

  assign m_axis_tuser = r_data[0];
  assign m_axis_tdata = {4'b0, r_data[OutBits+AddrBits:1]};
endmodule
